[design/dbled_pkg.sv]
// shared types and constants for the double-buffered led group scan block
package dbled_pkg;

    localparam int NUM_GROUPS_DEF      = 4;
    localparam int BYTES_PER_GROUP_DEF = 4;

    localparam int CMD_W  = 2;
    localparam int IDX_W  = 4;
    localparam int BYTE_W = 8;
    localparam int APB_DW = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_OR_SET = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_SWAP   = 2'd2,
        CMD_SCAN   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RMW,
        S_SEL,
        S_DATA
    } scan_state_t;

    // frame memory control group
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_en;
        logic clr_half;
    } mem_ctl_t;

endpackage

[design/dbled_if.sv]
// item channel interfaces for the command input and the byte output

interface dbled_in_if;
    import dbled_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] set_mask;

    modport source (output valid, output cmd, output byte_index, output set_mask,
                    input ready);
    modport sink   (input valid, input cmd, input byte_index, input set_mask,
                    output ready);
endinterface

interface dbled_out_if;
    import dbled_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

[design/dbled_frame_mem.sv]
// frame memory holding both buffers, with per-entry valid bits for fast clear
module dbled_frame_mem #(
    parameter int AW = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dbled_pkg::mem_ctl_t          ctl,
    input  logic [AW:0]                  rd_addr,
    input  logic [AW:0]                  wr_addr,
    input  logic [dbled_pkg::BYTE_W-1:0] wr_data,
    output logic [dbled_pkg::BYTE_W-1:0] rd_data
);
    import dbled_pkg::*;

    localparam int DEPTH = 2 ** (AW + 1);
    localparam int HALF  = DEPTH / 2;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    logic [DEPTH-1:0]  vld_next;
    logic [BYTE_W-1:0] rd_raw_reg;
    logic              rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
            rd_hit_reg <= vld_reg[rd_addr];
        end
    end

    // a clear drops the valid bits of one half; writes mark an entry valid
    always_comb
    begin
        vld_next = vld_reg;
        if (ctl.clr_en)
        begin
            if (ctl.clr_half)
            begin
                vld_next[DEPTH-1 -: HALF] = '0;
            end
            else
            begin
                vld_next[HALF-1:0] = '0;
            end
        end
        if (ctl.wr_en)
        begin
            vld_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign rd_data = rd_hit_reg ? rd_raw_reg : '0;

endmodule

[design/dbled_apb_regs.sv]
// apb register file with the per-group select bytes
module dbled_apb_regs #(
    parameter int NUM_GROUPS = dbled_pkg::NUM_GROUPS_DEF,
    parameter int GW         = 2,
    parameter int PAW        = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [PAW-1:0]               paddr,
    input  logic [dbled_pkg::APB_DW-1:0] pwdata,
    output logic [dbled_pkg::APB_DW-1:0] prdata,
    output logic                         pready,
    input  logic [GW-1:0]                grp,
    output logic [dbled_pkg::BYTE_W-1:0] sel_byte
);
    import dbled_pkg::*;

    logic [BYTE_W-1:0] sel_reg [NUM_GROUPS];
    logic [GW-1:0]     reg_idx;
    logic              idx_ok;
    logic              wr_fire;

    assign reg_idx = paddr[PAW-1:2];
    assign idx_ok  = (32'(reg_idx) < NUM_GROUPS);
    assign wr_fire = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_GROUPS; i++)
            begin
                sel_reg[i] <= '0;
            end
        end
        else if (wr_fire && idx_ok)
        begin
            sel_reg[reg_idx] <= pwdata[BYTE_W-1:0];
        end
    end

    assign prdata   = idx_ok ? APB_DW'(sel_reg[reg_idx]) : '0;
    assign sel_byte = sel_reg[grp];

endmodule

[design/double_buffered_led_group_scan.sv]
// top level of the double-buffered led group scan block
//
// double-buffered frame store for a multiplexed led panel of NUM_GROUPS groups,
// BYTES_PER_GROUP bytes each. commands arrive as items on cmd_ch (valid/ready):
// or-set a mask into a back buffer byte, clear the back buffer, swap front and
// back, or scan tick. a scan tick advances the group counter and then sends the
// group select byte followed by the group's front bytes, highest first, on
// scan_ch; the final byte carries last_byte.
// both buffers share one frame memory with a registered read; all
// work goes through its single read port, one command at a time.
// or-set reads, then writes back in S_RMW; clear and swap take effect on acceptance.
// a scan tick holds the command side in S_SEL and S_DATA until the final byte
// reaches the output register; the select byte is loaded into the output register
// in S_SEL, then the front bytes follow one byte per cycle while scan_ch is not stalled.
// the output register lets the next command be taken while the final byte waits.
// a stall on scan_ch holds the output register and the read stage; no reads
// are issued until space frees, so nothing is lost.
// reset clears both buffers (valid bits, no sweep), the select registers, the
// group counter and selects buffer a as front; the first tick shows group one.
// select bytes are written over apb, register i at byte address 4*i.
module double_buffered_led_group_scan #(
    parameter int NUM_GROUPS      = dbled_pkg::NUM_GROUPS_DEF,
    parameter int BYTES_PER_GROUP = dbled_pkg::BYTES_PER_GROUP_DEF,
    parameter int GW              = $clog2(NUM_GROUPS),
    parameter int PAW             = $clog2(NUM_GROUPS) + 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    dbled_in_if.sink                     cmd_ch,
    dbled_out_if.source                  scan_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [PAW-1:0]               paddr,
    input  logic [dbled_pkg::APB_DW-1:0] pwdata,
    output logic [dbled_pkg::APB_DW-1:0] prdata,
    output logic                         pready
);
    import dbled_pkg::*;

    localparam int FRAME_BYTES = NUM_GROUPS * BYTES_PER_GROUP;
    localparam int AW          = $clog2(FRAME_BYTES);
    localparam int KW          = (BYTES_PER_GROUP > 1) ? $clog2(BYTES_PER_GROUP) : 1;

    scan_state_t       state_reg;
    scan_state_t       state_next;

    logic              front_reg;      // 1: buffer b is front
    logic [GW-1:0]     group_reg;
    logic [GW-1:0]     group_inc;
    logic [KW-1:0]     k_reg;          // byte offset of the next scan read
    logic              issue_done_reg;
    logic [AW:0]       rmw_addr_reg;
    logic [BYTE_W-1:0] rmw_mask_reg;
    logic              rd_valid_reg;   // read stage holds a scan byte
    logic              rd_last_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;

    logic              in_fire;
    cmd_t              cmd;
    logic              in_range;
    logic [AW-1:0]     idx_a;
    logic [AW-1:0]     scan_addr;
    logic              out_free;
    logic              move_rd;
    logic              issue_en;
    logic              sel_load;
    logic              rmw_rd;

    mem_ctl_t          mem_ctl;
    logic [AW:0]       mem_rd_addr;
    logic [BYTE_W-1:0] mem_rd_data;
    logic [BYTE_W-1:0] sel_byte;

    // ---------------- command decode ----------------
    assign cmd      = cmd_t'(cmd_ch.cmd);
    assign in_fire  = cmd_ch.valid && cmd_ch.ready;
    assign in_range = (32'(cmd_ch.byte_index) < FRAME_BYTES);
    assign idx_a    = AW'(cmd_ch.byte_index);
    assign group_inc = (group_reg == GW'(NUM_GROUPS - 1)) ? '0 : group_reg + 1'b1;

    // scan byte address within the front half
    assign scan_addr = AW'(32'(group_reg) * BYTES_PER_GROUP + 32'(k_reg));

    // ---------------- output handshake ----------------
    assign out_free = !out_valid_reg || scan_ch.ready;
    assign move_rd  = rd_valid_reg && out_free;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (cmd)
                        CMD_OR_SET: state_next = in_range ? S_RMW : S_IDLE;
                        CMD_SCAN:   state_next = S_SEL;
                        CMD_CLEAR,
                        CMD_SWAP:   state_next = S_IDLE;
                    endcase
                end
            end
            S_RMW:  state_next = S_IDLE;
            S_SEL:
            begin
                if (out_free)
                begin
                    state_next = S_DATA;
                end
            end
            S_DATA:
            begin
                if (move_rd && rd_last_reg)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb
    begin
        cmd_ch.ready = 1'b0;
        sel_load     = 1'b0;
        issue_en     = 1'b0;
        unique case (state_reg)
            S_IDLE: cmd_ch.ready = 1'b1;
            S_RMW:  cmd_ch.ready = 1'b0;
            S_SEL:
            begin
                // select byte goes out while the first data read starts
                sel_load = out_free;
                issue_en = out_free;
            end
            S_DATA: issue_en = !issue_done_reg && (!rd_valid_reg || move_rd);
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            front_reg      <= 1'b0;
            group_reg      <= '0;
            k_reg          <= '0;
            issue_done_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_fire && cmd == CMD_SWAP)
            begin
                front_reg <= !front_reg;
            end

            if (in_fire && cmd == CMD_SCAN)
            begin
                group_reg      <= group_inc;
                k_reg          <= KW'(BYTES_PER_GROUP - 1);
                issue_done_reg <= 1'b0;
            end
            else if (issue_en)
            begin
                k_reg <= k_reg - 1'b1;
                if (k_reg == '0)
                begin
                    issue_done_reg <= 1'b1;
                end
            end

            // read stage: filled by a scan read, drained into the output register
            if (issue_en)
            begin
                rd_valid_reg <= 1'b1;
                rd_last_reg  <= (k_reg == '0);
            end
            else if (move_rd)
            begin
                rd_valid_reg <= 1'b0;
            end

            // output register
            if (sel_load)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= 1'b0;
            end
            else if (move_rd)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= rd_last_reg;
            end
            else if (scan_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rmw_addr_reg <= {!front_reg, idx_a};
            rmw_mask_reg <= cmd_ch.set_mask;
        end
        if (sel_load)
        begin
            out_byte_reg <= sel_byte;
        end
        else if (move_rd)
        begin
            out_byte_reg <= mem_rd_data;
        end
    end

    // ---------------- frame memory ----------------
    // or-set reads in the accept cycle, writes back in S_RMW; ready is low
    // during the write so no other access can touch the same entry
    assign rmw_rd           = in_fire && (cmd == CMD_OR_SET) && in_range;
    assign mem_ctl.rd_en    = rmw_rd || issue_en;
    assign mem_ctl.wr_en    = (state_reg == S_RMW);
    assign mem_ctl.clr_en   = in_fire && (cmd == CMD_CLEAR);
    assign mem_ctl.clr_half = !front_reg;
    assign mem_rd_addr      = issue_en ? {front_reg, scan_addr} : {!front_reg, idx_a};

    dbled_frame_mem #(
        .AW (AW)
    ) u_frame_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .rd_addr (mem_rd_addr),
        .wr_addr (rmw_addr_reg),
        .wr_data (mem_rd_data | rmw_mask_reg),
        .rd_data (mem_rd_data)
    );

    // ---------------- configuration ----------------
    dbled_apb_regs #(
        .NUM_GROUPS (NUM_GROUPS),
        .GW         (GW),
        .PAW        (PAW)
    ) u_apb_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .grp      (group_reg),
        .sel_byte (sel_byte)
    );

    assign scan_ch.valid     = out_valid_reg;
    assign scan_ch.out_byte  = out_byte_reg;
    assign scan_ch.last_byte = out_last_reg;

`ifndef SYNTHESIS
    // a read-modify-write always returns to idle straight after S_RMW
    a_rmw_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RMW |=> state_reg == S_IDLE)
        else $error("or-set write back did not return to idle");

    // a byte in the read stage is kept while the output cannot take it
    a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg && !out_free |=> rd_valid_reg && $stable(mem_rd_data))
        else $error("read stage lost a scan byte under stall");

    // the select byte is never marked as the final byte
    a_sel_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        sel_load |=> out_valid_reg && !out_last_reg && rd_valid_reg)
        else $error("select byte load malformed");
`endif

endmodule

[dv/tb_top.sv]
// self-checking testbench for the double-buffered led group scan block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dbled_pkg::*;

    localparam int FRAME_BYTES = NUM_GROUPS_DEF * BYTES_PER_GROUP_DEF;
    localparam int ADDR_W      = $clog2(NUM_GROUPS_DEF) + 2;
    localparam int PHASES      = 4;
    localparam int PHASE_ITEMS = 75;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 8;

    // one byte on its way to the panel
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } panel_byte_t;

    // mirror of the frame store: both buffers, front select, group counter
    // and the select bytes; queues the bytes each scan tick must send
    class led_frame_scoreboard;
        logic [BYTE_W-1:0] frame_a [FRAME_BYTES];
        logic [BYTE_W-1:0] frame_b [FRAME_BYTES];
        bit                front_b;
        logic [1:0]        group;
        logic [BYTE_W-1:0] group_sel [NUM_GROUPS_DEF];
        panel_byte_t       pending_bytes [$];
        int                mismatches;
        int                ops_seen [4];
        int                bytes_checked;

        function new();
            foreach (frame_a[i]) frame_a[i] = '0;
            foreach (frame_b[i]) frame_b[i] = '0;
            foreach (group_sel[i]) group_sel[i] = '0;
            foreach (ops_seen[i]) ops_seen[i] = 0;
            front_b       = 1'b0;
            group         = '0;
            mismatches    = 0;
            bytes_checked = 0;
        endfunction

        function void write_select(int idx, logic [APB_DW-1:0] value);
            if (idx < NUM_GROUPS_DEF)
                group_sel[idx] = value[BYTE_W-1:0];
        endfunction

        function void note_command(cmd_t op, logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] mask);
            int          base;
            panel_byte_t pb;
            ops_seen[int'(op)]++;
            case (op)
                CMD_OR_SET:
                    if (int'(idx) < FRAME_BYTES)
                    begin
                        if (front_b)
                            frame_a[idx] |= mask;
                        else
                            frame_b[idx] |= mask;
                    end
                CMD_CLEAR:
                    for (int i = 0; i < FRAME_BYTES; i++)
                    begin
                        if (front_b)
                            frame_a[i] = '0;
                        else
                            frame_b[i] = '0;
                    end
                CMD_SWAP:
                    front_b = !front_b;
                default:
                begin
                    group = group + 2'd1;
                    base  = int'(group) * BYTES_PER_GROUP_DEF;
                    pb.data = group_sel[group];
                    pb.last = 1'b0;
                    pending_bytes.push_back(pb);
                    for (int k = BYTES_PER_GROUP_DEF - 1; k >= 0; k--)
                    begin
                        pb.data = front_b ? frame_b[base + k] : frame_a[base + k];
                        pb.last = (k == 0);
                        pending_bytes.push_back(pb);
                    end
                end
            endcase
        endfunction

        function void check_byte(logic [BYTE_W-1:0] data, logic last);
            panel_byte_t exp_b;
            bytes_checked++;
            if (pending_bytes.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected byte: expected none, actual out_byte=%02h last_byte=%0b",
                         $time, data, last);
                return;
            end
            exp_b = pending_bytes.pop_front();
            if (data !== exp_b.data)
            begin
                mismatches++;
                $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                         $time, exp_b.data, data);
            end
            if (last !== exp_b.last)
            begin
                mismatches++;
                $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                         $time, exp_b.last, last);
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    dbled_in_if  cmd_if ();
    dbled_out_if scan_if ();

    led_frame_scoreboard sb = new();

    // both sides idle at random unless this is set
    bit quiet_phase   = 1'b0;
    // raised by the stimulus, cleared by the receiver once its long hold is over
    bit long_hold_req = 1'b0;

    double_buffered_led_group_scan uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_ch  (cmd_if),
        .scan_ch (scan_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // every accepted byte is checked against the oldest pending one
    always @(posedge clk)
    begin
        if (rst_n && scan_if.valid && scan_if.ready)
            sb.check_byte(scan_if.out_byte, scan_if.last_byte);
    end

    // receiver: random run and stall bursts, plus one long hold on request
    initial
    begin
        int burst_len;
        scan_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                // long hold so the block fills up and backs up its command side
                scan_if.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_req = 1'b0;
            end
            if (!quiet_phase && $urandom_range(0, 2) == 0)
            begin
                scan_if.ready = 1'b0;
                burst_len = $urandom_range(1, 16);
            end
            else
            begin
                scan_if.ready = 1'b1;
                burst_len = $urandom_range(1, 24);
            end
            repeat (burst_len - 1) @(negedge clk);
        end
    end

    // hold one command until taken, then update the mirror; returns at a falling edge
    task automatic push_command(cmd_t op, logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] mask);
        cmd_if.valid      = 1'b1;
        cmd_if.cmd        = op;
        cmd_if.byte_index = idx;
        cmd_if.set_mask   = mask;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        sb.note_command(op, idx, mask);
        @(negedge clk);
    endtask

    // occasional gap on the command side, with junk on the payload
    task automatic sender_gap();
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            cmd_if.valid      = 1'b0;
            cmd_if.cmd        = cmd_t'($urandom_range(0, 3));
            cmd_if.byte_index = IDX_W'($urandom_range(0, 15));
            cmd_if.set_mask   = BYTE_W'($urandom_range(0, 255));
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    endtask

    // stop sending and wait until every queued byte has arrived, then let
    // a pending read-modify-write finish before any register is touched
    task automatic wait_drain();
        cmd_if.valid = 1'b0;
        while (sb.pending_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // apb write with setup and access phases; upper bits of the word carry junk that must be dropped
    task automatic write_group_select(int idx, logic [BYTE_W-1:0] sel_byte);
        logic [APB_DW-1:0] word;
        word           = $urandom;
        word[BYTE_W-1:0] = sel_byte;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(idx * 4);
        pwdata  = word;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_select(idx, word);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // weighted pick: mostly drawing and scanning, a few swaps and clears
    function automatic cmd_t pick_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return CMD_OR_SET;
        else if (roll < 46)
            return CMD_CLEAR;
        else if (roll < 58)
            return CMD_SWAP;
        return CMD_SCAN;
    endfunction

    // stimulus
    initial
    begin
        logic [BYTE_W-1:0] first_sels [NUM_GROUPS_DEF];
        logic [BYTE_W-1:0] sel_byte;
        cmd_t              op;

        first_sels = '{8'h00, 8'hFF, 8'h5A, 8'hA5};

        rst_n             = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.cmd        = CMD_OR_SET;
        cmd_if.byte_index = '0;
        cmd_if.set_mask   = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // first tick after reset shows group one with reset selects and empty frames
        push_command(CMD_SCAN, 4'd0, 8'h00);
        wait_drain();
        for (int g = 0; g < NUM_GROUPS_DEF; g++)
            write_group_select(g, first_sels[g]);

        // draw into the back buffer, including repeated or onto the same byte
        push_command(CMD_OR_SET, 4'd0, 8'hFF);
        push_command(CMD_OR_SET, 4'd15, 8'h01);
        push_command(CMD_OR_SET, 4'd15, 8'h80);
        push_command(CMD_OR_SET, 4'd7, 8'h00);
        push_command(CMD_OR_SET, 4'd6, 8'h5A);
        // front still empty
        push_command(CMD_SCAN, 4'd0, 8'h00);
        push_command(CMD_SWAP, 4'd0, 8'h00);
        // counter wraps through three and back to zero
        push_command(CMD_SCAN, 4'd0, 8'h00);
        push_command(CMD_SCAN, 4'd0, 8'h00);
        push_command(CMD_SCAN, 4'd0, 8'h00);
        // clear wipes the back only, front stays
        push_command(CMD_OR_SET, 4'd3, 8'h3C);
        push_command(CMD_CLEAR, 4'd0, 8'h00);
        push_command(CMD_SWAP, 4'd0, 8'h00);
        push_command(CMD_SCAN, 4'd0, 8'h00);
        push_command(CMD_SWAP, 4'd0, 8'h00);
        push_command(CMD_CLEAR, 4'd0, 8'h00);
        push_command(CMD_SCAN, 4'd0, 8'h00);
        push_command(CMD_OR_SET, 4'd12, 8'hF0);
        push_command(CMD_SWAP, 4'd0, 8'h00);
        push_command(CMD_SCAN, 4'd0, 8'h00);
        push_command(CMD_SCAN, 4'd0, 8'h00);
        // back-to-back ticks with the payload fields at their top values
        push_command(CMD_SCAN, 4'd15, 8'hFF);
        wait_drain();

        // random phases, a new select setting before each; the last runs flat out
        for (int p = 0; p < PHASES; p++)
        begin
            quiet_phase = (p == PHASES - 1);
            for (int g = 0; g < NUM_GROUPS_DEF; g++)
            begin
                case (p)
                    1:       sel_byte = 8'hFF;
                    2:       sel_byte = 8'h00;
                    default: sel_byte = BYTE_W'($urandom_range(0, 255));
                endcase
                write_group_select(g, sel_byte);
            end
            // receiver holds off while commands keep coming
            if (p == 1)
                long_hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                op = pick_op();
                push_command(op, IDX_W'($urandom_range(0, 15)),
                             BYTE_W'($urandom_range(0, 255)));
                sender_gap();
                // one pause mid-phase until the panel side has caught up
                if (p == 0 && n == PHASE_ITEMS / 2)
                    wait_drain();
            end
            wait_drain();
        end

        repeat (20) @(posedge clk);

        $display("covered %0d or-sets, %0d clears, %0d swaps, %0d scan ticks, %0d bytes checked",
                 sb.ops_seen[int'(CMD_OR_SET)], sb.ops_seen[int'(CMD_CLEAR)],
                 sb.ops_seen[int'(CMD_SWAP)], sb.ops_seen[int'(CMD_SCAN)], sb.bytes_checked);
        $display("select settings: mixed, all ones, all zeros, random; one long panel-side hold");
        if (sb.mismatches == 0)
            $display("[double_buffered_led_group_scan] OK");
        else
            $display("[double_buffered_led_group_scan] ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("timeout with %0d bytes still pending", sb.pending_bytes.size());
        $display("[double_buffered_led_group_scan] ERROR");
        $finish;
    end

endmodule
